// ===== rtl/boxavg_pkg.sv =====
// ============================================================================
// boxavg_pkg
// Shared types and constants for the box average downscaler.
// ============================================================================
package boxavg_pkg;

    localparam int NUM_CH = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_FACTOR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_FACTOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd2;

    typedef struct packed {
        logic       frame_start;
        logic [7:0] in_blue;
        logic [7:0] in_green;
        logic [7:0] in_red;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic       row_end;
    } t_pix_out;

    // controller -> datapath
    typedef struct packed {
        logic accept;    // latch pixel, apply frame clear, start column-count divide
        logic step;      // update sums, counters and column memory
        logic div_sums;  // start the block-mean divide
        logic load_out;  // move quotients into the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
        logic emit;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/boxavg_div.sv =====
// ============================================================================
// boxavg_div
// Three-lane restoring divider, one quotient bit per cycle, shared divisor.
// ============================================================================
module boxavg_div #(
    parameter int DIV_W = 14,
    parameter int DVS_W = 7
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_start,
    input  logic [boxavg_pkg::NUM_CH-1:0][DIV_W-1:0]    i_dividend,
    input  logic [DVS_W-1:0]                            i_divisor,
    output logic [boxavg_pkg::NUM_CH-1:0][DIV_W-1:0]    o_quotient,
    output logic                                        o_done
);
    localparam int CW = (DIV_W > 1) ? $clog2(DIV_W) : 1;

    logic                                     r_busy;
    logic [CW-1:0]                            r_cnt;
    logic [boxavg_pkg::NUM_CH-1:0][DIV_W-1:0] r_q;
    logic [boxavg_pkg::NUM_CH-1:0][DVS_W-1:0] r_rem;
    logic [DVS_W-1:0]                         r_d;
    logic [boxavg_pkg::NUM_CH-1:0][DIV_W-1:0] n_q;
    logic [boxavg_pkg::NUM_CH-1:0][DVS_W-1:0] n_rem;
    logic [DVS_W:0]                           shifted;

    assign o_done     = r_busy && (r_cnt == CW'(DIV_W - 1));
    assign o_quotient = r_q;

    always_comb begin
        shifted = '0;
        for (int c = 0; c < boxavg_pkg::NUM_CH; c++) begin
            shifted = {r_rem[c], r_q[c][DIV_W-1]};
            if (shifted >= {1'b0, r_d}) begin
                n_rem[c] = DVS_W'(shifted - {1'b0, r_d});
                n_q[c]   = {r_q[c][DIV_W-2:0], 1'b1};
            end else begin
                n_rem[c] = shifted[DVS_W-1:0];
                n_q[c]   = {r_q[c][DIV_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (o_done) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

endmodule

// ===== rtl/boxavg_ctrl.sv =====
// ============================================================================
// boxavg_ctrl
// Sequencer: accept, column-count divide, step, mean divide, output load.
// ============================================================================
module boxavg_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  boxavg_pkg::t_status i_status,
    output boxavg_pkg::t_cmd    o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIVC = 5'b00010,
        S_STEP = 5'b00100,
        S_DIVS = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DIVC;
                end
            end
            S_DIVC: begin
                if (i_status.div_done) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                if (i_status.emit) begin
                    o_cmd.div_sums = 1'b1;
                    n_state        = S_DIVS;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIVS: begin
                if (i_status.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/boxavg_dp.sv =====
// ============================================================================
// boxavg_dp
// Datapath: config registers, position counters, column-sum memory, output.
// ============================================================================
module boxavg_dp #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_FACTOR = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [boxavg_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [boxavg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  boxavg_pkg::t_pix_in                  i_in_data,
    input  logic                                 i_out_stall,
    output logic                                 o_out_valid,
    output boxavg_pkg::t_pix_out                 o_out_data,
    input  boxavg_pkg::t_cmd                     i_cmd,
    output boxavg_pkg::t_status                  o_status
);
    localparam int NC     = boxavg_pkg::NUM_CH;
    localparam int CNT_W  = $clog2(MAX_WIDTH + 1);
    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int FAC_W  = $clog2(MAX_FACTOR + 1);
    localparam int HS_W   = $clog2(MAX_FACTOR * 255 + 1);
    localparam int SUM_W  = $clog2(MAX_FACTOR * MAX_FACTOR * 255 + 1);
    localparam int DVS_W  = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
    localparam int DIV_W  = (SUM_W > CNT_W) ? SUM_W : CNT_W;

    // config
    logic [3:0]  r_wf_raw;
    logic [3:0]  r_hf_raw;
    logic [11:0] r_w_raw;
    logic [FAC_W-1:0] wf;
    logic [FAC_W-1:0] hf;
    logic [CNT_W-1:0] w;
    logic [DVS_W-1:0] area;

    // position state
    logic [NC-1:0][HS_W-1:0] r_hs;
    logic [CNT_W-1:0]        r_in_col;
    logic [CNT_W-1:0]        r_out_col;
    logic [FAC_W-1:0]        r_cib;
    logic [FAC_W-1:0]        r_rib;
    logic [NC-1:0][7:0]      r_px;
    logic                    r_row_end;

    logic [NC-1:0][HS_W-1:0] n_hs;
    logic [CNT_W-1:0]        n_in_col;
    logic [CNT_W-1:0]        n_out_col;
    logic [FAC_W-1:0]        n_cib;
    logic [FAC_W-1:0]        n_rib;

    // column-sum memory
    logic [NC*SUM_W-1:0]     mem [MAX_WIDTH];
    logic [NC*SUM_W-1:0]     r_rd;
    logic [NC-1:0][SUM_W-1:0] rd_sums;
    logic [NC-1:0][SUM_W-1:0] new_cs;
    logic [ADDR_W-1:0]       addr;

    // divider
    logic                       div_start;
    logic [NC-1:0][DIV_W-1:0]   div_dividend;
    logic [DVS_W-1:0]           div_divisor;
    logic [NC-1:0][DIV_W-1:0]   div_q;
    logic                       div_done;

    // step terms
    logic [CNT_W-1:0]        cols;
    logic                    in_range;
    logic [NC-1:0][HS_W-1:0] hs_add;
    logic [FAC_W-1:0]        cib_inc;
    logic [FAC_W-1:0]        rib_inc;
    logic [CNT_W-1:0]        in_inc;
    logic [CNT_W-1:0]        out_inc;
    logic                    col_done;
    logic                    last_row;
    logic                    row_wrap;
    logic                    r_out_valid;
    boxavg_pkg::t_pix_out    r_out_data;

    // zero acts as one, oversize clamps to the maximum
    always_comb begin
        if (r_wf_raw == '0) begin
            wf = FAC_W'(1);
        end else if (32'(r_wf_raw) > MAX_FACTOR) begin
            wf = FAC_W'(MAX_FACTOR);
        end else begin
            wf = FAC_W'(r_wf_raw);
        end
        if (r_hf_raw == '0) begin
            hf = FAC_W'(1);
        end else if (32'(r_hf_raw) > MAX_FACTOR) begin
            hf = FAC_W'(MAX_FACTOR);
        end else begin
            hf = FAC_W'(r_hf_raw);
        end
        if (r_w_raw == '0) begin
            w = CNT_W'(1);
        end else if (32'(r_w_raw) > MAX_WIDTH) begin
            w = CNT_W'(MAX_WIDTH);
        end else begin
            w = CNT_W'(r_w_raw);
        end
        area = DVS_W'(32'(wf) * 32'(hf));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wf_raw <= 4'd2;
            r_hf_raw <= 4'd2;
            r_w_raw  <= 12'd640;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                boxavg_pkg::CFG_WIDTH_FACTOR:  r_wf_raw <= i_cfg_data[3:0];
                boxavg_pkg::CFG_HEIGHT_FACTOR: r_hf_raw <= i_cfg_data[3:0];
                boxavg_pkg::CFG_IMAGE_WIDTH:   r_w_raw  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign cols     = div_q[0][CNT_W-1:0];
    assign addr     = r_out_col[ADDR_W-1:0];
    assign rd_sums  = r_rd;
    assign in_range = (r_out_col < cols);
    assign cib_inc  = r_cib + 1'b1;
    assign rib_inc  = r_rib + 1'b1;
    assign in_inc   = r_in_col + 1'b1;
    assign out_inc  = r_out_col + 1'b1;
    assign col_done = in_range && (cib_inc >= wf);
    assign last_row = (rib_inc >= hf);
    assign row_wrap = (in_inc >= w);

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            hs_add[c] = r_hs[c] + HS_W'(r_px[c]);
            if (r_rib == '0) begin
                new_cs[c] = SUM_W'(hs_add[c]);
            end else begin
                new_cs[c] = rd_sums[c] + SUM_W'(hs_add[c]);
            end
        end

        n_hs      = r_hs;
        n_cib     = r_cib;
        n_out_col = r_out_col;
        n_rib     = r_rib;
        n_in_col  = in_inc;
        if (in_range) begin
            if (col_done) begin
                n_hs      = '0;
                n_cib     = '0;
                n_out_col = out_inc;
            end else begin
                n_hs  = hs_add;
                n_cib = cib_inc;
            end
        end
        if (row_wrap) begin
            n_in_col  = '0;
            n_out_col = '0;
            n_cib     = '0;
            n_hs      = '0;
            n_rib     = last_row ? '0 : rib_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hs      <= '0;
            r_in_col  <= '0;
            r_out_col <= '0;
            r_cib     <= '0;
            r_rib     <= '0;
        end else if (i_cmd.accept && i_in_data.frame_start) begin
            r_hs      <= '0;
            r_in_col  <= '0;
            r_out_col <= '0;
            r_cib     <= '0;
            r_rib     <= '0;
        end else if (i_cmd.step) begin
            r_hs      <= n_hs;
            r_in_col  <= n_in_col;
            r_out_col <= n_out_col;
            r_cib     <= n_cib;
            r_rib     <= n_rib;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_px <= {i_in_data.in_blue, i_in_data.in_green, i_in_data.in_red};
        end
        if (i_cmd.step) begin
            r_row_end <= (out_inc == cols);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && col_done) begin
            mem[addr] <= new_cs;
        end
        r_rd <= mem[addr];
    end

    // divider: column count first, block means after the last row
    always_comb begin
        div_start    = i_cmd.accept || i_cmd.div_sums;
        div_dividend = '0;
        div_divisor  = area;
        if (i_cmd.accept) begin
            div_dividend[0] = DIV_W'(w);
            div_divisor     = DVS_W'(wf);
        end else begin
            for (int c = 0; c < NC; c++) begin
                div_dividend[c] = DIV_W'(new_cs[c]);
            end
        end
    end

    boxavg_div #(
        .DIV_W (DIV_W),
        .DVS_W (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (div_q),
        .o_done     (div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data.out_blue  <= div_q[2][7:0];
            r_out_data.out_green <= div_q[1][7:0];
            r_out_data.out_red   <= div_q[0][7:0];
            r_out_data.row_end   <= r_row_end;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;
    assign o_status.div_done = div_done;
    assign o_status.emit     = col_done && last_row;
    assign o_status.out_free = !r_out_valid || !i_out_stall;

endmodule

// ===== rtl/box_average_downscaler_top.sv =====
// ============================================================================
// box_average_downscaler_top
// Box-average downscaler for a raster stream of 8-bit BGR pixels.
// ============================================================================
// Order: a pixel that completes a block passes the column-count divide, the step,
//   the mean divide and the output load before its result shows.
// Input: a new pixel is taken only when the sequencer is back in idle, after the load
//   if a result is made; the shared bit-serial divider gives one quotient bit per cycle.
// Reset (synchronous, active low): counters and sums clear, registers return to
//   width_factor 2, height_factor 2, image_width 640; column memory is not cleared.
// ============================================================================
//
// Structure
//   boxavg_ctrl  one-hot sequencer; o_in_stall is low only while idle.
//   boxavg_dp    config registers, position counters, per-column sum memory
//                (one word per output column, B/G/R packed), output register.
//   boxavg_div   three-lane restoring divider, shared between the column
//                count (image_width / width_factor) and the block means.
//
// Per transaction
//   accept : pixel latched, frame_start clears position, column-count divide starts
//   divide : column sum for the current output column is read meanwhile
//   step   : horizontal sum and counters advance; on a finished block column
//            the memory word is written (overwritten on the first row of a band)
//   mean   : on the last row of the band the three sums are divided by the area
//   load   : result goes to the output register once it is free
// The output register lets a new pixel be taken while a result is still stalled.
//
module box_average_downscaler_top #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_FACTOR = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [boxavg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [boxavg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // pixel input
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  boxavg_pkg::t_pix_in               i_in_data,
    // result output
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output boxavg_pkg::t_pix_out              o_out_data
);
    boxavg_pkg::t_cmd    cmd;
    boxavg_pkg::t_status status;

    boxavg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    boxavg_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule
